>>> rtl/llwd_pkg.sv
// Shared types and constants for the least-load weighted dispatcher.
`timescale 1ns / 1ps
package llwd_pkg;

  localparam int SERVER_IDX_W = 2;
  localparam int LOAD_W       = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int WEIGHT_W     = 8;
  localparam int SRV_USE_W    = 3;
  localparam int NUM_WEIGHTS  = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_SERVERS_IN_USE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_ZERO    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_ONE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_TWO     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_THREE   = 3'd4;

  localparam logic [SRV_USE_W-1:0] SRV_USE_RESET = 3'd4;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET  = 8'd1;

  typedef enum logic {
    REQ_ROUTE    = 1'b0,
    REQ_COMPLETE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_ROUTED    = 2'd0,
    ST_COMPLETED = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

endpackage

>>> rtl/least_load_weighted_dispatcher.sv
// Top level of the least-load weighted dispatcher: item register, pick logic, result register.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o   | req_type_i, server_index_i
//  out     | out_valid_o / out_ready_i | chosen_server_o, status_o, server_load_o
//  cfg     | cfg_we_i (no wait)        | cfg_addr_i, cfg_wdata_i
//
// One item per cycle sustained while out_ready_i is high; each item passes from acceptance
// to result through the item register, then the result register. The count compare over at most
// four servers and the count update sit between those two registers.
// Reset clears the counts to zero and loads the register reset values; no clearing pass.
// A stalled result holds in place; the item register still takes one item while it is empty.
`timescale 1ns / 1ps
module least_load_weighted_dispatcher #(
  parameter int NUM_SERVERS = 4,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [llwd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [llwd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [llwd_pkg::SERVER_IDX_W-1:0]   server_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [llwd_pkg::SERVER_IDX_W-1:0]   chosen_server_o,
  output logic [1:0]                          status_o,
  output logic [llwd_pkg::LOAD_W-1:0]         server_load_o
);
  import llwd_pkg::*;

  // Only four servers can be named by the index fields.
  localparam int NSLOT  = (NUM_SERVERS < NUM_WEIGHTS) ? NUM_SERVERS : NUM_WEIGHTS;
  localparam int WIDE_W = (COUNT_BITS > LOAD_W) ? COUNT_BITS : LOAD_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SRV_USE_W-1:0]  SLOT_LIM = SRV_USE_W'(NSLOT);

  // Configuration registers
  logic [SRV_USE_W-1:0] srv_use_q;
  logic [WEIGHT_W-1:0]  weight_q [NUM_WEIGHTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_use_q <= SRV_USE_RESET;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_q[i] <= WEIGHT_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SERVERS_IN_USE: srv_use_q   <= cfg_wdata_i[SRV_USE_W-1:0];
        REG_WEIGHT_ZERO:    weight_q[0] <= cfg_wdata_i;
        REG_WEIGHT_ONE:     weight_q[1] <= cfg_wdata_i;
        REG_WEIGHT_TWO:     weight_q[2] <= cfg_wdata_i;
        REG_WEIGHT_THREE:   weight_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Enabled server count, clamped to 1..NSLOT
  logic [SRV_USE_W-1:0] en_n;
  always_comb begin
    en_n = srv_use_q;
    if (en_n == '0) begin
      en_n = SRV_USE_W'(1);
    end
    if (en_n > SLOT_LIM) begin
      en_n = SLOT_LIM;
    end
  end

  // Item register
  logic                    s1_valid_q;
  req_type_e               s1_type_q;
  logic [SERVER_IDX_W-1:0] s1_idx_q;
  logic                    s1_adv;
  logic                    out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_type_q <= req_type_e'(req_type_i);
      s1_idx_q  <= server_index_i;
    end
  end

  // Pick and count update
  logic [COUNT_BITS-1:0]   count_q [NSLOT];
  logic [SERVER_IDX_W-1:0] best_idx;
  logic [COUNT_BITS-1:0]   best_cnt;
  logic [WEIGHT_W-1:0]     best_wt;
  logic [COUNT_BITS-1:0]   sel_cnt;
  logic [SERVER_IDX_W-1:0] tgt_idx;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic                    cnt_we;
  status_e                 status_d;
  logic [WIDE_W-1:0]       load_wide;

  always_comb begin
    best_idx = '0;
    best_cnt = count_q[0];
    best_wt  = weight_q[0];
    for (int i = 1; i < NSLOT; i++) begin
      if ((SRV_USE_W'(i) < en_n) &&
          ((count_q[i] < best_cnt) ||
           ((count_q[i] == best_cnt) && (weight_q[i] > best_wt)))) begin
        best_idx = SERVER_IDX_W'(i);
        best_cnt = count_q[i];
        best_wt  = weight_q[i];
      end
    end
  end

  always_comb begin
    sel_cnt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (s1_idx_q == SERVER_IDX_W'(i)) begin
        sel_cnt = count_q[i];
      end
    end
  end

  always_comb begin
    cnt_we = 1'b0;
    if (s1_type_q == REQ_ROUTE) begin
      tgt_idx = best_idx;
      if (best_cnt == CNT_MAX) begin
        new_cnt  = CNT_MAX;
        status_d = ST_SATURATED;
      end else begin
        new_cnt  = best_cnt + COUNT_BITS'(1);
        status_d = ST_ROUTED;
        cnt_we   = 1'b1;
      end
    end else begin
      tgt_idx = s1_idx_q;
      if ({1'b0, s1_idx_q} >= en_n) begin
        new_cnt  = sel_cnt;
        status_d = ST_IGNORED;
      end else if (sel_cnt == '0) begin
        new_cnt  = '0;
        status_d = ST_IGNORED;
      end else begin
        new_cnt  = sel_cnt - COUNT_BITS'(1);
        status_d = ST_COMPLETED;
        cnt_we   = 1'b1;
      end
    end
    load_wide = WIDE_W'(new_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        count_q[i] <= '0;
      end
    end else if (s1_adv && cnt_we) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tgt_idx == SERVER_IDX_W'(i)) begin
          count_q[i] <= new_cnt;
        end
      end
    end
  end

  // Result register
  logic [SERVER_IDX_W-1:0] chosen_q;
  status_e                 status_q;
  logic [LOAD_W-1:0]       load_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      chosen_q <= tgt_idx;
      status_q <= status_d;
      load_q   <= load_wide[LOAD_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_server_o = chosen_q;
  assign status_o        = status_q;
  assign server_load_o   = load_q;

endmodule

>>> rtl/llwd_checker.sv
// Port-level checks for the least-load weighted dispatcher, bound to the top level.
`timescale 1ns / 1ps
module llwd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [llwd_pkg::SERVER_IDX_W-1:0]   chosen_server_o,
  input  logic [1:0]                          status_o,
  input  logic [llwd_pkg::LOAD_W-1:0]         server_load_o
);
  import llwd_pkg::*;

  logic in_acc;
  logic out_acc;
  logic [1:0] pend_q;
  logic [1:0] pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track items taken in but not yet delivered.
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_server_o) &&
      $stable(status_o) && $stable(server_load_o))
    else $error("result changed while stalled");

  // With the output side empty the block must take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no result pending");

  // At most two items in flight: the item register and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items in flight");

  // No result without an item behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result shown with no item accepted");

endmodule

bind least_load_weighted_dispatcher llwd_checker u_llwd_checker (.*);

>>> tb/sv/least_load_weighted_dispatcher_tb.sv
// Testbench for the least-load weighted dispatcher: directed table, then random phases.
`timescale 1ns / 1ps
module least_load_weighted_dispatcher_tb;
  import llwd_pkg::*;

  typedef struct packed {
    logic [SERVER_IDX_W-1:0] srv;
    status_e                 st;
    logic [LOAD_W-1:0]       load;
  } dispatch_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    req_type_e               req;
    logic [SERVER_IDX_W-1:0] idx;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   data;
    bit                      typed;
    dispatch_t               want;
  } dir_row_t;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [LOAD_W-1:0]     LOAD_MAX     = '1;
  localparam int                    MAX_PRINTS   = 20;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic                    req_type_i     = 1'b0;
  logic [SERVER_IDX_W-1:0] server_index_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [SERVER_IDX_W-1:0] chosen_server_o;
  logic [1:0]              status_o;
  logic [LOAD_W-1:0]       server_load_o;

  // predictor state
  logic [LOAD_W-1:0]    track_load   [NUM_WEIGHTS];
  logic [WEIGHT_W-1:0]  track_weight [NUM_WEIGHTS];
  logic [SRV_USE_W-1:0] track_use;

  dispatch_t awaited[$];
  int        mismatches = 0;
  int        idle_pct   = 0;
  int        stall_pct  = 0;

  least_load_weighted_dispatcher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .server_index_i (server_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chosen_server_o(chosen_server_o),
    .status_o       (status_o),
    .server_load_o  (server_load_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int live_servers();
    int n;
    n = int'(track_use);
    if (n == 0) n = 1;
    if (n > NUM_WEIGHTS) n = NUM_WEIGHTS;
    return n;
  endfunction

  function automatic dispatch_t pick_and_update(req_type_e t, logic [SERVER_IDX_W-1:0] idx);
    int        n;
    int        best;
    dispatch_t r;
    n = live_servers();
    if (t == REQ_ROUTE) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (track_load[i] < track_load[best] ||
            (track_load[i] == track_load[best] && track_weight[i] > track_weight[best])) begin
          best = i;
        end
      end
      if (track_load[best] == LOAD_MAX) begin
        r.st = ST_SATURATED;
      end else begin
        track_load[best] = track_load[best] + 1'b1;
        r.st = ST_ROUTED;
      end
      r.srv  = SERVER_IDX_W'(best);
      r.load = track_load[best];
    end else begin
      r.srv = idx;
      // unused or idle server: leave the count alone
      if (int'(idx) >= n || track_load[idx] == '0) begin
        r.st = ST_IGNORED;
      end else begin
        track_load[idx] = track_load[idx] - 1'b1;
        r.st = ST_COMPLETED;
      end
      r.load = track_load[idx];
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("MISMATCH at %0t ns: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  // check results and drive the receiver's ready
  always @(posedge clk_i) begin
    dispatch_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing awaited, load", server_load_o, 0);
      end else begin
        want = awaited.pop_front();
        if (chosen_server_o !== want.srv) flag_mismatch("chosen_server", chosen_server_o, want.srv);
        if (status_o !== want.st) flag_mismatch("status", status_o, want.st);
        if (server_load_o !== want.load) flag_mismatch("server_load", server_load_o, want.load);
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(req_type_e t, logic [SERVER_IDX_W-1:0] idx, bit typed,
                           dispatch_t want);
    dispatch_t got;
    in_valid_i     <= 1'b1;
    req_type_i     <= t;
    server_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    got = pick_and_update(t, idx);
    awaited = {awaited, (typed ? want : got)};
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      REG_SERVERS_IN_USE: track_use       = data[SRV_USE_W-1:0];
      REG_WEIGHT_ZERO:    track_weight[0] = data;
      REG_WEIGHT_ONE:     track_weight[1] = data;
      REG_WEIGHT_TWO:     track_weight[2] = data;
      REG_WEIGHT_THREE:   track_weight[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [SRV_USE_W-1:0] n, logic [WEIGHT_W-1:0] w0,
                             logic [WEIGHT_W-1:0] w1, logic [WEIGHT_W-1:0] w2,
                             logic [WEIGHT_W-1:0] w3);
    // upper bits of servers_in_use are don't-care; fill them with noise
    write_reg(REG_SERVERS_IN_USE, {(CFG_DATA_W-SRV_USE_W)'($urandom), n});
    write_reg(REG_WEIGHT_ZERO, w0);
    write_reg(REG_WEIGHT_ONE, w1);
    write_reg(REG_WEIGHT_TWO, w2);
    write_reg(REG_WEIGHT_THREE, w3);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(99) < 55) begin
        send_item(REQ_ROUTE, SERVER_IDX_W'($urandom), 1'b0, '0);
      end else begin
        send_item(REQ_COMPLETE, SERVER_IDX_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  function automatic dir_row_t item_row(req_type_e t, logic [SERVER_IDX_W-1:0] idx, bit typed,
                                        dispatch_t want);
    dir_row_t r;
    r       = '{kind: ROW_ITEM, req: t, idx: idx, addr: '0, data: '0, typed: typed, want: want};
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{kind: ROW_REG, req: REQ_ROUTE, idx: '0, addr: addr, data: data, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    track_use = SRV_USE_RESET;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      track_load[i]   = '0;
      track_weight[i] = WEIGHT_RESET;
    end

    // after reset: all idle, equal weights, lowest index wins ties
    rows = {rows, item_row(REQ_COMPLETE, 2'd0, 1'b1, '{2'd0, ST_IGNORED, 16'd0})};
    rows = {rows, item_row(REQ_COMPLETE, 2'd3, 1'b1, '{2'd3, ST_IGNORED, 16'd0})};
    rows = {rows, item_row(REQ_ROUTE, 2'd3, 1'b1, '{2'd0, ST_ROUTED, 16'd1})};
    rows = {rows, item_row(REQ_ROUTE, 2'd0, 1'b1, '{2'd1, ST_ROUTED, 16'd1})};
    rows = {rows, item_row(REQ_ROUTE, 2'd1, 1'b1, '{2'd2, ST_ROUTED, 16'd1})};
    rows = {rows, item_row(REQ_ROUTE, 2'd2, 1'b1, '{2'd3, ST_ROUTED, 16'd1})};
    rows = {rows, item_row(REQ_ROUTE, 2'd0, 1'b1, '{2'd0, ST_ROUTED, 16'd2})};
    rows = {rows, item_row(REQ_COMPLETE, 2'd2, 1'b1, '{2'd2, ST_COMPLETED, 16'd0})};
    rows = {rows, item_row(REQ_ROUTE, 2'd0, 1'b1, '{2'd2, ST_ROUTED, 16'd1})};
    // weight breaks the tie
    rows = {rows, reg_row(REG_WEIGHT_THREE, 8'd255)};
    rows = {rows, reg_row(REG_WEIGHT_ZERO, 8'd0)};
    rows = {rows, item_row(REQ_ROUTE, 2'd0, 1'b0, '0)};
    rows = {rows, item_row(REQ_ROUTE, 2'd0, 1'b0, '0)};
    // zero servers acts as one; completes to others are ignored
    rows = {rows, reg_row(REG_SERVERS_IN_USE, 8'd0)};
    rows = {rows, item_row(REQ_ROUTE, 2'd2, 1'b0, '0)};
    rows = {rows, item_row(REQ_COMPLETE, 2'd1, 1'b0, '0)};
    rows = {rows, item_row(REQ_COMPLETE, 2'd0, 1'b0, '0)};
    // write to an unmapped index, then an oversized server count
    rows = {rows, reg_row(REG_UNMAPPED, 8'hFF)};
    rows = {rows, reg_row(REG_SERVERS_IN_USE, 8'hFF)};
    rows = {rows, item_row(REQ_ROUTE, 2'd1, 1'b0, '0)};
    rows = {rows, item_row(REQ_COMPLETE, 2'd3, 1'b0, '0)};
    rows = {rows, reg_row(REG_SERVERS_IN_USE, 8'd2)};
    rows = {rows, reg_row(REG_WEIGHT_ONE, 8'd255)};
    rows = {rows, item_row(REQ_COMPLETE, 2'd3, 1'b0, '0)};
    rows = {rows, item_row(REQ_ROUTE, 2'd3, 1'b0, '0)};
    rows = {rows, item_row(REQ_ROUTE, 2'd2, 1'b0, '0)};
    rows = {rows, item_row(REQ_COMPLETE, 2'd1, 1'b0, '0)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_REG) begin
        write_reg(rows[k].addr, rows[k].data);
      end else begin
        send_item(rows[k].req, rows[k].idx, rows[k].typed, rows[k].want);
      end
    end

    load_config(3'd4, 8'd0, 8'd255, 8'd255, 8'd0);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(300);

    load_config(3'd3, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    idle_pct = 66;
    run_random(300);

    load_config(3'd1, 8'd255, 8'd0, 8'($urandom), 8'($urandom));
    idle_pct  = 0;
    stall_pct = 66;
    run_random(200);

    load_config(3'd2, 8'd9, 8'd9, 8'($urandom), 8'($urandom));
    idle_pct  = 10;
    stall_pct = 10;
    run_random(200);

    load_config(3'd6, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    idle_pct  = 0;
    stall_pct = 0;
    run_random(200);

    // two servers enabled, then one last route and complete
    write_reg(REG_SERVERS_IN_USE, 8'd2);
    send_item(REQ_ROUTE, 2'd0, 1'b0, '0);
    send_item(REQ_COMPLETE, 2'd0, 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
